// ----- hdl/wtd_pkg.sv -----
package wtd_pkg;

  localparam int TableDepth  = 8;
  localparam int SlotW       = $clog2(TableDepth);
  localparam int CordicSteps = 14;
  localparam int StepW       = $clog2(CordicSteps + 1);

  localparam logic [1:0] OP_POSE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_SETTLE = 3'd1;
  localparam logic [2:0] MODE_TURN   = 3'd2;
  localparam logic [2:0] MODE_MOVE   = 3'd3;
  localparam logic [2:0] MODE_STOP   = 3'd4;

  localparam logic [1:0] END_NEXT     = 2'd0;
  localparam logic [1:0] END_TELEPORT = 2'd1;
  localparam logic [1:0] END_STOP     = 2'd2;

  // Result kinds, chosen by the controller and decoded by the datapath.
  localparam logic [1:0] K_ZERO  = 2'd0;
  localparam logic [1:0] K_TURN  = 2'd1;
  localparam logic [1:0] K_DRIVE = 2'd2;
  localparam logic [1:0] K_START = 2'd3;

  localparam logic signed [15:0] PiQ12    = 16'sd12868;
  localparam logic signed [15:0] TwoPiQ12 = 16'sd25736;
  localparam logic signed [39:0] HalfPiQ24 = 40'sd26353589;

  localparam int RegAddrW = 3;
  localparam logic [2:0] REG_START_X   = 3'd0;
  localparam logic [2:0] REG_START_Y   = 3'd1;
  localparam logic [2:0] REG_SETTLE    = 3'd2;
  localparam logic [2:0] REG_ARRIVE    = 3'd3;
  localparam logic [2:0] REG_HEAD_TOL  = 3'd4;
  localparam logic [2:0] REG_TURN_RATE = 3'd5;
  localparam logic [2:0] REG_CRUISE    = 3'd6;
  localparam logic [2:0] REG_GAIN      = 3'd7;

  function automatic logic signed [39:0] atan_q24(input logic [4:0] i);
    case (i)
      5'd0:  atan_q24 = 40'sd13176795;
      5'd1:  atan_q24 = 40'sd7778716;
      5'd2:  atan_q24 = 40'sd4110060;
      5'd3:  atan_q24 = 40'sd2086331;
      5'd4:  atan_q24 = 40'sd1047214;
      5'd5:  atan_q24 = 40'sd524117;
      5'd6:  atan_q24 = 40'sd262123;
      5'd7:  atan_q24 = 40'sd131069;
      5'd8:  atan_q24 = 40'sd65536;
      5'd9:  atan_q24 = 40'sd32768;
      5'd10: atan_q24 = 40'sd16384;
      5'd11: atan_q24 = 40'sd8192;
      5'd12: atan_q24 = 40'sd4096;
      5'd13: atan_q24 = 40'sd2048;
      5'd14: atan_q24 = 40'sd1024;
      5'd15: atan_q24 = 40'sd512;
      5'd16: atan_q24 = 40'sd256;
      5'd17: atan_q24 = 40'sd128;
      5'd18: atan_q24 = 40'sd64;
      5'd19: atan_q24 = 40'sd32;
      default: atan_q24 = 40'sd0;
    endcase
  endfunction

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture pose fields
    logic sq_settle; // square start-point differences
    logic sq_target; // square target differences
    logic cordic_init;
    logic cordic_step;
    logic err_calc;  // form wrapped heading error
    logic mul_gain;  // error times gain
  } wtd_cmd_t;

  // Datapath status back to controller.
  typedef struct packed {
    logic settled;     // within settle tolerance
    logic arrived;     // within arrive tolerance
    logic cordic_done;
    logic turn_done;   // |err| within heading tolerance
  } wtd_sts_t;

endpackage

// ----- hdl/wtd_ctrl.sv -----
module wtd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             op_i,
  input  logic [2:0]             entry_index_i,
  input  logic [1:0]             end_mark_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output wtd_pkg::wtd_cmd_t      cmd_o,
  input  wtd_pkg::wtd_sts_t      sts_i,
  output logic                   tbl_we_o,
  output logic [wtd_pkg::SlotW-1:0] slot_o,
  output logic [2:0]             mode_o,
  output logic                   res_set_o,
  output logic [1:0]             res_kind_o
);
  import wtd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQ     = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_CORDIC = 3'd3;
  localparam logic [2:0] S_ERR    = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_DECIDE = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] mode_q, mode_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign mode_o      = mode_q;
  assign slot_o      = slot_q;
  assign tbl_we_o    = accept && (op_i == OP_WRITE) &&
                       ({1'b0, entry_index_i} < 4'(TableDepth));

  always_comb begin
    state_d = state_q;
    mode_d = mode_q;
    slot_d = slot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o = '0;
    res_set_o = 1'b0;
    res_kind_o = K_ZERO;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (op_i == OP_START) begin
            slot_d = '0;
            mode_d = MODE_SETTLE;
            res_set_o = 1'b1;
            res_kind_o = K_START;
            out_valid_d = 1'b1;
          end else if (op_i == OP_POSE && (mode_q == MODE_SETTLE ||
                       mode_q == MODE_TURN || mode_q == MODE_MOVE)) begin
            state_d = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd_o.sq_settle = (mode_q == MODE_SETTLE);
        cmd_o.sq_target = (mode_q != MODE_SETTLE);
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (mode_q == MODE_SETTLE) begin
          if (sts_i.settled) begin
            mode_d = MODE_TURN;
            state_d = S_SQ;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.cordic_init = 1'b1;
          state_d = S_CORDIC;
        end
      end
      S_CORDIC: begin
        if (sts_i.cordic_done) state_d = S_ERR;
        else cmd_o.cordic_step = 1'b1;
      end
      S_ERR: begin
        cmd_o.err_calc = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_gain = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        res_set_o = 1'b1;
        out_valid_d = 1'b1;
        state_d = S_IDLE;
        if (mode_q == MODE_TURN) begin
          if (sts_i.turn_done) begin
            mode_d = MODE_MOVE;
            res_kind_o = K_ZERO;
          end else begin
            res_kind_o = K_TURN;
          end
        end else if (!sts_i.arrived) begin
          res_kind_o = K_DRIVE;
        end else begin
          res_kind_o = K_ZERO;
          if (end_mark_i == END_NEXT || end_mark_i == END_TELEPORT) begin
            slot_d = (32'(slot_q) + 1 >= TableDepth) ? '0 : slot_q + 1'b1;
            mode_d = (end_mark_i == END_NEXT) ? MODE_TURN : MODE_SETTLE;
          end else begin
            mode_d = MODE_STOP;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= MODE_IDLE;
      slot_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      slot_q <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

// ----- hdl/wtd_datapath.sv -----
module wtd_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wtd_pkg::wtd_cmd_t      cmd_i,
  output wtd_pkg::wtd_sts_t      sts_o,
  input  logic signed [15:0]     pose_x_i,
  input  logic signed [15:0]     pose_y_i,
  input  logic signed [14:0]     pose_heading_i,
  input  logic [2:0]             entry_index_i,
  input  logic signed [15:0]     entry_x_i,
  input  logic signed [15:0]     entry_y_i,
  input  logic [1:0]             entry_end_i,
  input  logic                   tbl_we_i,
  input  logic [wtd_pkg::SlotW-1:0] slot_i,
  input  logic [2:0]             mode_i,
  input  logic                   res_set_i,
  input  logic [1:0]             res_kind_i,
  output logic [1:0]             end_mark_o,
  input  logic [14:0]            start_x_i,
  input  logic [14:0]            start_y_i,
  input  logic [14:0]            settle_tol_i,
  input  logic [14:0]            arrive_tol_i,
  input  logic [14:0]            head_tol_i,
  input  logic [14:0]            turn_rate_i,
  input  logic [14:0]            cruise_i,
  input  logic [14:0]            gain_i,
  output logic [14:0]            linear_speed_o,
  output logic signed [15:0]     angular_rate_o,
  output logic                   teleport_request_o,
  output logic [2:0]             mode_now_o,
  output logic [2:0]             target_slot_o,
  output logic                   run_done_o
);
  import wtd_pkg::*;

  logic signed [15:0] tx [TableDepth];
  logic signed [15:0] ty [TableDepth];
  logic [1:0]         te [TableDepth];

  logic signed [15:0] px_q, py_q;
  logic signed [14:0] ph_q;
  logic signed [17:0] dx_q, dy_q;
  logic [35:0] d2_q;
  logic signed [39:0] cx_q, cy_q, cz_q;
  logic [StepW-1:0] step_q;
  logic zero_q;
  logic signed [15:0] err_q;
  logic signed [31:0] prod_q;
  logic [14:0] lin_q;
  logic signed [15:0] ang_q, ang_d;
  logic tele_q, done_q, tele_d, done_d;

  always_ff @(posedge clk_i) begin
    if (tbl_we_i) begin
      tx[entry_index_i[SlotW-1:0]] <= entry_x_i;
      ty[entry_index_i[SlotW-1:0]] <= entry_y_i;
      te[entry_index_i[SlotW-1:0]] <= entry_end_i;
    end
  end

  assign end_mark_o = te[slot_i];

  // Squared distance: the mode picks start point or target.
  logic signed [17:0] ddx, ddy;
  logic [35:0] sqx, sqy;
  always_comb begin
    if (cmd_i.sq_settle) begin
      ddx = 18'(px_q) - 18'($signed({1'b0, start_x_i}));
      ddy = 18'(py_q) - 18'($signed({1'b0, start_y_i}));
    end else begin
      ddx = 18'(tx[slot_i]) - 18'(px_q);
      ddy = 18'(ty[slot_i]) - 18'(py_q);
    end
    sqx = 36'(ddx) * 36'(ddx);
    sqy = 36'(ddy) * 36'(ddy);
  end

  logic [29:0] settle_sq, arrive_sq;
  assign settle_sq = 30'(settle_tol_i) * 30'(settle_tol_i);
  assign arrive_sq = 30'(arrive_tol_i) * 30'(arrive_tol_i);

  // One CORDIC vectoring rotation per cycle.
  logic signed [39:0] x0, y0, xs, ys;
  always_comb begin
    x0 = 40'(dx_q) <<< 20;
    y0 = 40'(dy_q) <<< 20;
    xs = cx_q >>> step_q;
    ys = cy_q >>> step_q;
  end

  logic signed [19:0] zr, e0, e1;
  logic signed [15:0] ew;
  logic [15:0] emag;
  logic signed [31:0] pm;
  logic [31:0] pabs;
  logic signed [32:0] at;
  always_comb begin
    zr = zero_q ? 20'sd0 : 20'((cz_q + 40'sd2048) >>> 12);
    e0 = zr - 20'(ph_q);
    if (e0 > 20'(PiQ12)) e1 = e0 - 20'(TwoPiQ12);
    else if (e0 < -20'(PiQ12)) e1 = e0 + 20'(TwoPiQ12);
    else e1 = e0;
    ew = 16'(e1);
    emag = err_q[15] ? 16'(-err_q) : 16'(err_q);
    pm = 32'(err_q) * 32'($signed({1'b0, gain_i}));
    pabs = prod_q[31] ? 32'(-prod_q) : 32'(prod_q);
    at = prod_q[31] ? -$signed({13'b0, pabs[31:12]}) : $signed({13'b0, pabs[31:12]});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= pose_x_i;
      py_q <= pose_y_i;
      ph_q <= pose_heading_i;
    end
    if (cmd_i.sq_settle || cmd_i.sq_target) begin
      dx_q <= ddx;
      dy_q <= ddy;
      d2_q <= sqx + sqy;
    end
    if (cmd_i.cordic_init) begin
      step_q <= '0;
      zero_q <= (dx_q == 0) && (dy_q == 0);
      if (x0 < 0) begin
        if (y0 >= 0) begin
          cx_q <= y0; cy_q <= -x0; cz_q <= HalfPiQ24;
        end else begin
          cx_q <= -y0; cy_q <= x0; cz_q <= -HalfPiQ24;
        end
      end else begin
        cx_q <= x0; cy_q <= y0; cz_q <= '0;
      end
    end else if (cmd_i.cordic_step) begin
      step_q <= step_q + 1'b1;
      if (cy_q > 0) begin
        cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + atan_q24(5'(step_q));
      end else begin
        cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - atan_q24(5'(step_q));
      end
    end
    if (cmd_i.err_calc) err_q <= ew;
    if (cmd_i.mul_gain) prod_q <= pm;
  end

  assign sts_o.settled     = ({1'b0, d2_q} < {7'b0, settle_sq});
  assign sts_o.arrived     = !({1'b0, d2_q} > {7'b0, arrive_sq});
  assign sts_o.cordic_done = (32'(step_q) >= CordicSteps);
  assign sts_o.turn_done   = !(emag > {1'b0, head_tol_i});

  // The result kind picks the command. A zero result marks an arrival only
  // when it is decided in moving mode.
  always_comb begin
    ang_d = '0;
    tele_d = 1'b0;
    done_d = 1'b0;
    case (res_kind_i)
      K_TURN: ang_d = err_q > 0 ? $signed({1'b0, turn_rate_i})
                                : -$signed({1'b0, turn_rate_i});
      K_DRIVE: ang_d = (at > 33'sd32767) ? 16'sd32767 :
                       (at < -33'sd32768) ? -16'sd32768 : 16'(at);
      K_START: tele_d = 1'b1;
      default: begin
        if (mode_i == MODE_MOVE && sts_o.arrived) begin
          if (end_mark_o == END_TELEPORT) tele_d = 1'b1;
          else if (end_mark_o != END_NEXT) done_d = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q <= '0; ang_q <= '0; tele_q <= 1'b0; done_q <= 1'b0;
    end else if (res_set_i) begin
      lin_q <= (res_kind_i == K_DRIVE) ? cruise_i : 15'd0;
      ang_q <= ang_d;
      tele_q <= tele_d;
      done_q <= done_d;
    end
  end

  // Mode and slot reported after the step.
  always_comb begin
    mode_now_o = mode_i;
    target_slot_o = 3'(slot_i);
  end

  assign linear_speed_o = lin_q;
  assign angular_rate_o = ang_q;
  assign teleport_request_o = tele_q;
  assign run_done_o = done_q;
endmodule

// ----- hdl/waypoint_turn_then_drive_follower.sv -----
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_ready_o   op_i, pose_*, entry_*
// result    out        out_valid_o / out_ready_i linear_speed_o ... run_done_o
// config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// A pose item in turning or moving mode squares distances and checks them,
// runs the 14-step iterative CORDIC, then forms the error, the gain product
// and the decision. A passing settle check first adds its own squaring and
// check; a failing one ends with no result. A write gives no result. The next
// item can be taken in the cycle after the result is taken.
// Reset is asynchronous and active low and clears mode, slot and handshakes.
// One item is in work at a time; a waiting result blocks the next item.
module waypoint_turn_then_drive_follower (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [14:0] pose_heading_i,
  input  logic [2:0]  entry_index_i,
  input  logic signed [15:0] entry_x_i,
  input  logic signed [15:0] entry_y_i,
  input  logic [1:0]  entry_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [14:0] linear_speed_o,
  output logic signed [15:0] angular_rate_o,
  output logic        teleport_request_o,
  output logic [2:0]  mode_now_o,
  output logic [2:0]  target_slot_o,
  output logic        run_done_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wtd_pkg::*;

  logic [14:0] regs_q [8];
  wtd_cmd_t cmd;
  wtd_sts_t sts;
  logic tbl_we, res_set;
  logic [SlotW-1:0] slot;
  logic [2:0] mode;
  logic [1:0] res_kind, end_mark;
  logic [RegAddrW-1:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  assign prdata = {17'b0, regs_q[ridx]};

  // Configuration registers; any write within the address range lands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[REG_START_X]   <= 15'd2048;
      regs_q[REG_START_Y]   <= 15'd2048;
      regs_q[REG_SETTLE]    <= 15'd1024;
      regs_q[REG_ARRIVE]    <= 15'd205;
      regs_q[REG_HEAD_TOL]  <= 15'd82;
      regs_q[REG_TURN_RATE] <= 15'd7373;
      regs_q[REG_CRUISE]    <= 15'd8192;
      regs_q[REG_GAIN]      <= 15'd8192;
    end else if (psel && penable && pwrite) begin
      regs_q[ridx] <= pwdata[14:0];
    end
  end

  wtd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .entry_index_i,
    .end_mark_i(end_mark), .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts), .tbl_we_o(tbl_we), .slot_o(slot), .mode_o(mode),
    .res_set_o(res_set), .res_kind_o(res_kind)
  );

  wtd_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .pose_x_i, .pose_y_i,
    .pose_heading_i, .entry_index_i, .entry_x_i, .entry_y_i, .entry_end_i,
    .tbl_we_i(tbl_we), .slot_i(slot), .mode_i(mode), .res_set_i(res_set),
    .res_kind_i(res_kind), .end_mark_o(end_mark),
    .start_x_i(regs_q[REG_START_X]), .start_y_i(regs_q[REG_START_Y]),
    .settle_tol_i(regs_q[REG_SETTLE]), .arrive_tol_i(regs_q[REG_ARRIVE]),
    .head_tol_i(regs_q[REG_HEAD_TOL]), .turn_rate_i(regs_q[REG_TURN_RATE]),
    .cruise_i(regs_q[REG_CRUISE]), .gain_i(regs_q[REG_GAIN]),
    .linear_speed_o, .angular_rate_o, .teleport_request_o,
    .mode_now_o, .target_slot_o, .run_done_o
  );

  // No new item while a result waits.
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("item taken while result waits");

  // A finished run reports a zero speed command.
  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && run_done_o) |-> (linear_speed_o == 15'd0))
    else $error("run done with nonzero speed");

  // Teleport and run done are never both asked.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(teleport_request_o && run_done_o))
    else $error("teleport and done together");
endmodule

// ----- bench/wtd_checker.sv -----
`timescale 1ns / 100ps

// Watches the item, result and register channels of the waypoint follower,
// keeps its own model of the controller and compares every result.
module wtd_checker
  import wtd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [14:0] pose_heading_i,
  input  logic [2:0]         entry_index_i,
  input  logic signed [15:0] entry_x_i,
  input  logic signed [15:0] entry_y_i,
  input  logic [1:0]         entry_end_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [14:0]        linear_speed_o,
  input  logic signed [15:0] angular_rate_o,
  input  logic               teleport_request_o,
  input  logic [2:0]         mode_now_o,
  input  logic [2:0]         target_slot_o,
  input  logic               run_done_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [14:0]        lin;
    logic signed [15:0] ang;
    logic               tele;
    logic [2:0]         mode;
    logic [2:0]         slot;
    logic               done;
  } command_t;

  localparam longint AtanQ24 [0:19] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
  };
  localparam longint RegReset [0:7] = '{2048, 2048, 1024, 205, 82, 7373, 8192, 8192};

  command_t    cmd_q[$];
  longint      regs[8];
  logic [2:0]  cur_mode;
  logic [2:0]  cur_slot;
  longint      way_x[TableDepth];
  longint      way_y[TableDepth];
  logic [1:0]  way_end[TableDepth];

  assign pending = cmd_q.size();

  // Vectoring CORDIC bearing, angles held in Q.24 and rounded to Q3.12.
  function automatic longint bearing_q12(input longint dy, input longint dx);
    longint x, y, z, t, xs, ys;
    x = dx * 1048576;
    y = dy * 1048576;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HalfPiQ24;
      end else begin
        t = x; x = -y; y = t; z = -HalfPiQ24;
      end
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += AtanQ24[i];
      end else begin
        x -= ys; y += xs; z -= AtanQ24[i];
      end
    end
    return (z + 2048) >>> 12;
  endfunction

  function automatic command_t make_cmd(input longint lin, input longint ang,
                                        input logic tele, input logic done);
    command_t c;
    c.lin  = lin[14:0];
    c.ang  = ang[15:0];
    c.tele = tele;
    c.mode = cur_mode;
    c.slot = cur_slot;
    c.done = done;
    return c;
  endfunction

  // Advances the controller copy by one accepted item and queues the command, if any.
  task automatic follow_item();
    longint px, py, ph, dx, dy, d2, tol, err, mag, p, ang;
    logic [2:0] s, s_next;
    px = pose_x_i;
    py = pose_y_i;
    ph = pose_heading_i;
    if (op_i == OP_WRITE) begin
      way_x[entry_index_i]   = entry_x_i;
      way_y[entry_index_i]   = entry_y_i;
      way_end[entry_index_i] = entry_end_i;
      return;
    end
    if (op_i == OP_START) begin
      cur_slot = '0;
      cur_mode = MODE_SETTLE;
      cmd_q.push_back(make_cmd(0, 0, 1'b1, 1'b0));
      return;
    end
    if (op_i != OP_POSE) return;
    if (cur_mode == MODE_SETTLE) begin
      dx  = px - regs[0];
      dy  = py - regs[1];
      tol = regs[2];
      if (dx * dx + dy * dy >= tol * tol) return;
      cur_mode = MODE_TURN;
    end
    if (cur_mode != MODE_TURN && cur_mode != MODE_MOVE) return;
    s   = cur_slot;
    s_next = (int'(s) + 1 >= TableDepth) ? 3'd0 : s + 3'd1;
    dx  = way_x[s] - px;
    dy  = way_y[s] - py;
    d2  = dx * dx + dy * dy;
    err = bearing_q12(dy, dx) - ph;
    while (err > PiQ12) err -= TwoPiQ12;
    while (err < -PiQ12) err += TwoPiQ12;
    if (cur_mode == MODE_TURN) begin
      mag = err < 0 ? -err : err;
      if (mag > regs[4]) begin
        cmd_q.push_back(make_cmd(0, err > 0 ? regs[5] : -regs[5], 1'b0, 1'b0));
      end else begin
        cur_mode = MODE_MOVE;
        cmd_q.push_back(make_cmd(0, 0, 1'b0, 1'b0));
      end
      return;
    end
    tol = regs[3];
    if (d2 > tol * tol) begin
      p   = err * regs[7];
      ang = p < 0 ? -((-p) >>> 12) : (p >>> 12);
      if (ang > 32767) ang = 32767;
      if (ang < -32768) ang = -32768;
      cmd_q.push_back(make_cmd(regs[6], ang, 1'b0, 1'b0));
    end else if (way_end[s] == END_NEXT) begin
      cur_slot = s_next;
      cur_mode = MODE_TURN;
      cmd_q.push_back(make_cmd(0, 0, 1'b0, 1'b0));
    end else if (way_end[s] == END_TELEPORT) begin
      cur_slot = s_next;
      cur_mode = MODE_SETTLE;
      cmd_q.push_back(make_cmd(0, 0, 1'b1, 1'b0));
    end else begin
      cur_mode = MODE_STOP;
      cmd_q.push_back(make_cmd(0, 0, 1'b0, 1'b1));
    end
  endtask

  task automatic report(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    command_t c;
    if (!rst_ni) begin
      cmd_q.delete();
      fail_count = 0;
      cur_mode   = MODE_IDLE;
      cur_slot   = '0;
      for (int i = 0; i < 8; i++) regs[i] = RegReset[i];
    end else begin
      if (psel && penable && pwrite && pready) regs[paddr[4:2]] = pwdata[14:0];
      if (in_valid_i && in_ready_o) follow_item();
      if (out_valid_o && out_ready_i) begin
        if (cmd_q.size() == 0) begin
          $display("%0t: result with no expected command, actual mode %0d",
                   $time, mode_now_o);
          fail_count++;
        end else begin
          c = cmd_q.pop_front();
          report("linear_speed", c.lin, linear_speed_o);
          report("angular_rate", c.ang, angular_rate_o);
          report("teleport_request", c.tele, teleport_request_o);
          report("mode_now", c.mode, mode_now_o);
          report("target_slot", c.slot, target_slot_o);
          report("run_done", c.done, run_done_o);
        end
      end
    end
  end

endmodule

// ----- bench/waypoint_turn_then_drive_follower_test.sv -----
`timescale 1ns / 100ps

// Top of the bench: clock, reset, stimulus and verdict. The verdict rests on
// the checker instance, which counts failures and reports how many
// commands are still owed by the block.
module waypoint_turn_then_drive_follower_test;
  import wtd_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         op_i;
  logic signed [15:0] pose_x_i;
  logic signed [15:0] pose_y_i;
  logic signed [14:0] pose_heading_i;
  logic [2:0]         entry_index_i;
  logic signed [15:0] entry_x_i;
  logic signed [15:0] entry_y_i;
  logic [1:0]         entry_end_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [14:0]        linear_speed_o;
  logic signed [15:0] angular_rate_o;
  logic               teleport_request_o;
  logic [2:0]         mode_now_o;
  logic [2:0]         target_slot_o;
  logic               run_done_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;

  // Shadows used only to steer the stimulus toward meaningful poses.
  int         path_x[8];
  int         path_y[8];
  int         knob[8];
  logic [2:0] seen_mode;
  logic [2:0] seen_slot;

  // While calm is set neither side inserts gaps.
  bit calm;
  int hold_asked;
  int hold_done;

  waypoint_turn_then_drive_follower dut (.*);

  wtd_checker checker_i (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("[waypoint_turn_then_drive_follower] ERROR");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Heading in Q3.12 that points from (px,py) to (wx,wy), plus some jitter.
  function automatic int aim(input int px, py, wx, wy, jitter);
    int h;
    h = $rtoi($atan2(real'(wy - py), real'(wx - px)) * 4096.0) + jitter;
    if (h > 12868) h = 12868;
    if (h < -12868) h = -12868;
    return h;
  endfunction

  // The receiver normally toggles ready at random; on request it holds off
  // for a long stretch so the block fills up and stops taking items.
  initial begin
    int run_len, g;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      run_len = $urandom_range(1, 12);
      repeat (run_len) @(posedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      seen_mode <= mode_now_o;
      seen_slot <= target_slot_o;
    end
  end

  // Offers one item and returns once it has been accepted and the gap after
  // it has passed.
  task automatic send(input logic [1:0] op, input int px, py, ph,
                      input int idx, ex, ey, en);
    int g;
    in_valid_i     <= 1'b1;
    op_i           <= op;
    pose_x_i       <= px[15:0];
    pose_y_i       <= py[15:0];
    pose_heading_i <= ph[14:0];
    entry_index_i  <= idx[2:0];
    entry_x_i      <= ex[15:0];
    entry_y_i      <= ey[15:0];
    entry_end_i    <= en[1:0];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op == OP_WRITE) begin
      path_x[idx] = ex;
      path_y[idx] = ey;
    end
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic pose(input int px, py, ph);
    send(OP_POSE, px, py, ph, 0, 0, 0, 0);
  endtask

  task automatic set_reg(input logic [2:0] idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value & 32'h7fff;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    knob[idx] = value & 32'h7fff;
  endtask

  // Waits until every owed command has come back, then lets a pose or a
  // write still in work run out before touching the registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_regs(input int sx, sy, settle, arrive, htol, rate, cruise, gain);
    set_reg(REG_START_X, sx);
    set_reg(REG_START_Y, sy);
    set_reg(REG_SETTLE, settle);
    set_reg(REG_ARRIVE, arrive);
    set_reg(REG_HEAD_TOL, htol);
    set_reg(REG_TURN_RATE, rate);
    set_reg(REG_CRUISE, cruise);
    set_reg(REG_GAIN, gain);
  endtask

  // One random item. Most are poses shaped after the mode the block last
  // reported, so runs get through settling, turning, moving and arrival;
  // the rest are table rewrites, restarts and plain noise.
  task automatic random_item();
    int r, px, py, w, reach, en;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      send(2'($urandom_range(0, 3)), $urandom_range(0, 65535) - 32768,
           $urandom_range(0, 65535) - 32768, $urandom_range(0, 25736) - 12868,
           $urandom_range(0, 7), $urandom_range(0, 65535) - 32768,
           $urandom_range(0, 65535) - 32768, $urandom_range(0, 2));
    end else if (r < 17) begin
      en = $urandom_range(0, 9);
      en = en < 7 ? END_NEXT : (en < 9 ? END_TELEPORT : END_STOP);
      send(OP_WRITE, 0, 0, 0, $urandom_range(0, 7), $urandom_range(0, 40000) - 20000,
           $urandom_range(0, 40000) - 20000, en);
    end else if (r < 19 || seen_mode == MODE_IDLE || seen_mode == MODE_STOP) begin
      send(OP_START, 0, 0, 0, 0, 0, 0, 0);
    end else if (seen_mode == MODE_SETTLE) begin
      reach = knob[REG_SETTLE] / 2 + 1;
      if ($urandom_range(0, 4) == 0) reach = 6000;
      px = clamp16(knob[REG_START_X] + $urandom_range(0, 2 * reach) - reach);
      py = clamp16(knob[REG_START_Y] + $urandom_range(0, 2 * reach) - reach);
      pose(px, py, $urandom_range(0, 25736) - 12868);
    end else begin
      w = seen_slot;
      reach = ($urandom_range(0, 2) == 0) ? knob[REG_ARRIVE] / 2 : 3000;
      px = clamp16(path_x[w] + $urandom_range(0, 2 * reach) - reach);
      py = clamp16(path_y[w] + $urandom_range(0, 2 * reach) - reach);
      if ($urandom_range(0, 3) == 0)
        pose(px, py, $urandom_range(0, 25736) - 12868);
      else
        pose(px, py, aim(px, py, path_x[w], path_y[w], $urandom_range(0, 120) - 60));
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = '0;
    pose_x_i       = '0;
    pose_y_i       = '0;
    pose_heading_i = '0;
    entry_index_i  = '0;
    entry_x_i      = '0;
    entry_y_i      = '0;
    entry_end_i    = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    calm           = 1'b0;
    hold_asked     = 0;
    hold_done      = 0;
    seen_mode      = MODE_IDLE;
    seen_slot      = '0;
    knob           = '{2048, 2048, 1024, 205, 82, 7373, 8192, 8192};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A pose while idle and the unused op give nothing.
    pose(0, 0, 0);
    send(OP_NONE, 100, 100, 100, 7, 100, 100, 1);
    // Fill every slot first so no unwritten entry is ever read. Slot two
    // ends a path with a teleport and slot seven ends the run.
    send(OP_WRITE, 0, 0, 0, 0, 32767, -32768, END_NEXT);
    send(OP_WRITE, 0, 0, 0, 1, -32768, 32767, END_NEXT);
    send(OP_WRITE, 0, 0, 0, 2, 4096, 4096, END_TELEPORT);
    send(OP_WRITE, 0, 0, 0, 3, -6000, 2000, END_NEXT);
    send(OP_WRITE, 0, 0, 0, 4, 8000, -3000, END_NEXT);
    send(OP_WRITE, 0, 0, 0, 5, 1000, 9000, END_NEXT);
    send(OP_WRITE, 0, 0, 0, 6, -9000, -9000, END_NEXT);
    send(OP_WRITE, 0, 0, 0, 7, 3000, 3000, END_STOP);
    send(OP_START, 0, 0, 0, 0, 0, 0, 0);
    // Far from the start point: still waiting to settle.
    pose(-32768, -32768, 0);
    // Settled, then turning both ways with headings at the extremes.
    pose(2048, 2048, 12868);
    pose(2048, 2048, -12868);
    pose(2048, 2048, aim(2048, 2048, 32767, -32768, 0));
    pose(2048, 2048, aim(2048, 2048, 32767, -32768, 900));
    // Arrival exactly on the waypoint, where the bearing vector is zero.
    pose(32767, -32768, 0);
    pose(-32768, 32767, 0);
    pose(-32768, 32767, 0);
    // Slot two ends the path and asks for a teleport.
    pose(0, 0, aim(0, 0, 4096, 4096, 0));
    pose(4096, 4096, 5000);
    pose(2048, 2048, aim(2048, 2048, -6000, 2000, 0));
    drain();

    // Random part in four register settings: typical values, the upper
    // extremes, the lower extremes, then a random mix.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_regs(3000, 1500, 2000, 400, 200, 5000, 12000, 20000);
        1: write_regs(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        2: write_regs(0, 0, 0, 0, 0, 0, 0, 0);
        default: write_regs($urandom_range(0, 32767), $urandom_range(0, 32767),
                            $urandom_range(0, 4000), $urandom_range(0, 1500),
                            $urandom_range(0, 600), $urandom_range(0, 32767),
                            $urandom_range(0, 32767), $urandom_range(0, 32767));
      endcase
      if (phase == 0) hold_asked++;
      for (int n = 0; n < 190; n++) begin
        if (n % 60 == 0) calm = ($urandom_range(0, 2) == 0);
        random_item();
      end
      calm = 1'b0;
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[waypoint_turn_then_drive_follower] OK");
    end else begin
      $display("[waypoint_turn_then_drive_follower] ERROR");
    end
    $finish;
  end

endmodule

// ----- waypoint_turn_then_drive_follower.f -----
hdl/wtd_pkg.sv
hdl/wtd_ctrl.sv
hdl/wtd_datapath.sv
hdl/waypoint_turn_then_drive_follower.sv
bench/wtd_checker.sv
bench/waypoint_turn_then_drive_follower_test.sv
